### hdl/rlwe_pkg.sv
// ----------------------------------------------------------------------------
// rlwe_pkg
// Shared sizes, codes and the fixed stage root table of the decryption core.
// ----------------------------------------------------------------------------
`default_nettype none

package rlwe_pkg;

    localparam int COEFFS = 256;
    localparam int IDX_W  = $clog2(COEFFS);
    localparam int HALF   = COEFFS / 2;
    localparam int NSTAGE = IDX_W - 1;
    localparam int STG_W  = $clog2(NSTAGE);
    localparam int DW     = 14;
    localparam int PROD_W = 2 * DW;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int CFG_W  = 3;

    localparam logic [CFG_W-1:0] CFG_MODULUS    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_MERGE_ROOT = 3'd1;
    localparam logic [CFG_W-1:0] CFG_ODD_TWIST  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_TWIST_ROOT = 3'd3;
    localparam logic [CFG_W-1:0] CFG_SCALE      = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic          go;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] c;
        logic [DW-1:0] q;
    } t_mm_req;

    function automatic logic [DW-1:0] stage_root(input logic [STG_W-1:0] idx);
        logic [DW-1:0] v;
        case (idx)
            3'd0:    v = 14'd7680;
            3'd1:    v = 14'd3383;
            3'd2:    v = 14'd5756;
            3'd3:    v = 14'd1728;
            3'd4:    v = 14'd7584;
            3'd5:    v = 14'd6569;
            default: v = 14'd6601;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/rlwe_ram.sv
// ----------------------------------------------------------------------------
// rlwe_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwe_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/rlwe_mulmod.sv
// ----------------------------------------------------------------------------
// rlwe_mulmod
// Computes (a*b + c) mod q by restoring reduction, one product bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwe_mulmod (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rlwe_pkg::t_mm_req    i_req,
    output logic                      o_done,
    output logic [rlwe_pkg::DW-1:0]   o_res
);

    logic [rlwe_pkg::PROD_W-1:0] r_x;
    logic [rlwe_pkg::DW-1:0]     r_rem;
    logic [rlwe_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rlwe_pkg::DW:0]       w_trial;
    logic [rlwe_pkg::DW-1:0]     n_rem;

    always_comb begin
        w_trial = {r_rem, r_x[rlwe_pkg::PROD_W-1]};
        if (w_trial >= {1'b0, i_req.q}) begin
            n_rem = rlwe_pkg::DW'(w_trial - {1'b0, i_req.q});
        end else begin
            n_rem = w_trial[rlwe_pkg::DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= rlwe_pkg::CNT_W'(rlwe_pkg::PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rlwe_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_x   <= rlwe_pkg::PROD_W'(i_req.a) * rlwe_pkg::PROD_W'(i_req.b)
                     + rlwe_pkg::PROD_W'(i_req.c);
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[rlwe_pkg::PROD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_rem;

endmodule

`default_nettype wire

### hdl/ring_lwe_decrypt_inverse_ntt.sv
// ----------------------------------------------------------------------------
// ring_lwe_decrypt_inverse_ntt
// Decryption core: stores c1*r2+c2 mod q per load, runs the packed inverse
// transform after the last load, then returns the coefficients on reads.
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser=operation, tdata=triple
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata=plain_coef, tlast=last
// cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// Every modular product runs through one shared multiplier and a bit-serial
// reducer. The transform after the last load runs about 3070 products and
// accepts no request meanwhile. Reset is synchronous and active low. A
// finished result stays in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_lwe_decrypt_inverse_ntt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [13:0] cipher_one, [27:14] cipher_two, [41:28] secret_coef, [47:42] zero
    input  wire logic [47:0] i_s_axis_tdata,
    // [0] operation
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [13:0] plain_coef, [15:14] zero
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);

    localparam int DW = rlwe_pkg::DW;
    localparam int IW = rlwe_pkg::IDX_W;
    localparam int JW = rlwe_pkg::IDX_W - 1;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_READ, S_TRD, S_TMOD, S_TWR, S_TNEXT, S_TUPD
    } t_state;

    typedef enum logic [1:0] {
        PH_BF, PH_MG, PH_FN
    } t_phase;

    t_state                       r_state;
    t_phase                       r_phase;
    logic [2:0]                   r_sub;
    logic [1:0]                   r_mi;
    logic                         r_wait;
    logic                         r_go;
    logic [DW-1:0]                r_ma, r_mb, r_mc;
    logic [rlwe_pkg::STG_W-1:0]   r_stage;
    logic [JW-1:0]                r_j, r_k;
    logic [DW-1:0]                r_omega, r_wo;
    logic [DW-1:0]                r_buf [4];
    logic [DW-1:0]                r_res [4];
    logic [IW-1:0]                r_ld_idx, r_rd_idx;
    logic                         r_result_ready;
    logic [DW-1:0]                r_modulus, r_merge_root, r_odd_twist, r_twist_root, r_scale;
    logic                         r_out_valid, r_out_last;
    logic [DW-1:0]                r_out_data;

    rlwe_pkg::t_mm_req            w_req;
    logic                         w_mm_done;
    logic [DW-1:0]                w_mm_res;
    logic [DW-1:0]                w_q;
    logic [JW-1:0]                w_half, w_p, w_r;
    logic [IW-1:0]                w_m, w_knext;
    logic [2:0]                   w_nrd;
    logic [1:0]                   w_nmod_last;
    logic                         w_we;
    logic [IW-1:0]                w_waddr, w_raddr;
    logic [DW-1:0]                w_wdata, w_rdata;
    logic [DW-1:0]                w_op_a, w_op_b, w_up_a, w_up_b;
    logic                         w_in_acc;

    function automatic logic [DW-1:0] addq(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] q);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] subq(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] q);
        logic [DW:0] s;
        s = {1'b0, a} + {1'b0, q} - {1'b0, b};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[DW-1:0];
    endfunction

    assign w_q      = (r_modulus == '0) ? DW'(1) : r_modulus;
    assign w_half   = JW'(1) << r_stage;
    assign w_m      = {w_half, 1'b0};
    assign w_knext  = {1'b0, r_k} + w_m;
    assign w_p      = r_k + r_j;
    assign w_r      = w_p + w_half;
    assign w_nrd    = (r_phase == PH_BF) ? 3'd4 : 3'd2;
    assign w_nmod_last = (r_phase == PH_MG) ? 2'd1 : 2'd3;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign o_cfg_ready     = (r_state == S_IDLE);

    assign w_req.go = r_go;
    assign w_req.a  = r_ma;
    assign w_req.b  = r_mb;
    assign w_req.c  = r_mc;
    assign w_req.q  = w_q;

    rlwe_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    rlwe_ram #(.WIDTH(DW), .DEPTH(rlwe_pkg::COEFFS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_raddr = r_rd_idx;
        if (r_state == S_TRD) begin
            if (r_phase == PH_BF) begin
                case (r_sub[1:0])
                    2'd0:    w_raddr = {w_p, 1'b0};
                    2'd1:    w_raddr = {w_p, 1'b1};
                    2'd2:    w_raddr = {w_r, 1'b0};
                    default: w_raddr = {w_r, 1'b1};
                endcase
            end else begin
                w_raddr = {r_j, r_sub[0]};
            end
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ld_idx;
        w_wdata = w_mm_res;
        if (r_state == S_LOAD) begin
            w_we = w_mm_done;
        end else if (r_state == S_TWR) begin
            w_we = 1'b1;
            case (r_phase)
                PH_BF: begin
                    case (r_sub[1:0])
                        2'd0: begin
                            w_waddr = {w_p, 1'b0};
                            w_wdata = addq(r_res[0], r_res[1], w_q);
                        end
                        2'd1: begin
                            w_waddr = {w_r, 1'b0};
                            w_wdata = subq(r_res[0], r_res[1], w_q);
                        end
                        2'd2: begin
                            w_waddr = {w_p, 1'b1};
                            w_wdata = addq(r_res[2], r_res[3], w_q);
                        end
                        default: begin
                            w_waddr = {w_r, 1'b1};
                            w_wdata = subq(r_res[2], r_res[3], w_q);
                        end
                    endcase
                end
                PH_MG: begin
                    w_waddr = {r_j, r_sub[0]};
                    w_wdata = r_sub[0] ? subq(r_res[0], r_res[1], w_q)
                                       : addq(r_res[0], r_res[1], w_q);
                end
                default: begin
                    w_waddr = {r_j, r_sub[0]};
                    w_wdata = r_sub[0] ? r_res[3] : r_res[1];
                end
            endcase
        end
    end

    always_comb begin
        w_op_a = DW'(1);
        w_op_b = r_buf[0];
        if (r_phase == PH_FN) begin
            case (r_mi)
                2'd0: begin
                    w_op_a = r_omega;
                    w_op_b = r_buf[0];
                end
                2'd1: begin
                    w_op_a = r_res[0];
                    w_op_b = r_scale;
                end
                2'd2: begin
                    w_op_a = r_wo;
                    w_op_b = r_buf[1];
                end
                default: begin
                    w_op_a = r_res[2];
                    w_op_b = r_scale;
                end
            endcase
        end else begin
            case (r_mi)
                2'd0: begin
                    w_op_a = DW'(1);
                    w_op_b = r_buf[0];
                end
                2'd1: begin
                    w_op_a = r_omega;
                    w_op_b = r_buf[1];
                end
                2'd2: begin
                    w_op_a = DW'(1);
                    w_op_b = r_buf[2];
                end
                default: begin
                    w_op_a = r_omega;
                    w_op_b = r_buf[3];
                end
            endcase
        end
        case (r_phase)
            PH_BF: begin
                w_up_a = r_omega;
                w_up_b = rlwe_pkg::stage_root(r_stage);
            end
            PH_MG: begin
                w_up_a = r_omega;
                w_up_b = r_merge_root;
            end
            default: begin
                w_up_a = r_mi[0] ? r_wo : r_omega;
                w_up_b = r_twist_root;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= PH_BF;
            r_sub          <= '0;
            r_mi           <= '0;
            r_wait         <= 1'b0;
            r_go           <= 1'b0;
            r_stage        <= '0;
            r_j            <= '0;
            r_k            <= '0;
            r_ld_idx       <= '0;
            r_rd_idx       <= '0;
            r_result_ready <= 1'b0;
            r_modulus      <= 14'd7681;
            r_merge_root   <= 14'd1;
            r_odd_twist    <= 14'd1;
            r_twist_root   <= 14'd1;
            r_scale        <= 14'd7651;
            r_out_valid    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rlwe_pkg::CFG_MODULUS:    r_modulus    <= i_cfg_data;
                    rlwe_pkg::CFG_MERGE_ROOT: r_merge_root <= i_cfg_data;
                    rlwe_pkg::CFG_ODD_TWIST:  r_odd_twist  <= i_cfg_data;
                    rlwe_pkg::CFG_TWIST_ROOT: r_twist_root <= i_cfg_data;
                    rlwe_pkg::CFG_SCALE:      r_scale      <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tuser == rlwe_pkg::OP_LOAD) begin
                            if (r_result_ready) begin
                                r_result_ready <= 1'b0;
                                r_rd_idx       <= '0;
                                r_ld_idx       <= '0;
                            end
                            r_ma    <= i_s_axis_tdata[13:0];
                            r_mb    <= i_s_axis_tdata[41:28];
                            r_mc    <= i_s_axis_tdata[27:14];
                            r_go    <= 1'b1;
                            r_state <= S_LOAD;
                        end else if (r_result_ready) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_LOAD: begin
                    if (w_mm_done) begin
                        if (r_ld_idx == IW'(rlwe_pkg::COEFFS - 1)) begin
                            r_ld_idx <= '0;
                            r_phase  <= PH_BF;
                            r_stage  <= '0;
                            r_j      <= '0;
                            r_k      <= '0;
                            r_omega  <= DW'(1);
                            r_sub    <= '0;
                            r_state  <= S_TRD;
                        end else begin
                            r_ld_idx <= r_ld_idx + 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= w_rdata;
                    r_out_last  <= (r_rd_idx == IW'(rlwe_pkg::COEFFS - 1));
                    if (r_rd_idx == IW'(rlwe_pkg::COEFFS - 1)) begin
                        r_result_ready <= 1'b0;
                        r_rd_idx       <= '0;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_TRD: begin
                    if (r_sub != 3'd0) begin
                        r_buf[r_sub[1:0] - 2'd1] <= w_rdata;
                    end
                    if (r_sub == w_nrd) begin
                        r_sub   <= '0;
                        r_mi    <= '0;
                        r_wait  <= 1'b0;
                        r_state <= S_TMOD;
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                S_TMOD: begin
                    if (!r_wait) begin
                        r_ma   <= w_op_a;
                        r_mb   <= w_op_b;
                        r_mc   <= '0;
                        r_go   <= 1'b1;
                        r_wait <= 1'b1;
                    end else if (w_mm_done) begin
                        r_res[r_mi] <= w_mm_res;
                        r_wait      <= 1'b0;
                        if (r_mi == w_nmod_last) begin
                            r_sub   <= '0;
                            r_state <= S_TWR;
                        end else begin
                            r_mi <= r_mi + 1'b1;
                        end
                    end
                end
                S_TWR: begin
                    if (r_sub == w_nrd - 3'd1) begin
                        r_state <= S_TNEXT;
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                S_TNEXT: begin
                    r_sub  <= '0;
                    r_mi   <= '0;
                    r_wait <= 1'b0;
                    if (r_phase == PH_BF && w_knext < IW'(rlwe_pkg::HALF)) begin
                        r_k     <= w_knext[JW-1:0];
                        r_state <= S_TRD;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_TUPD;
                    end
                end
                S_TUPD: begin
                    if (!r_wait) begin
                        r_ma   <= w_up_a;
                        r_mb   <= w_up_b;
                        r_mc   <= '0;
                        r_go   <= 1'b1;
                        r_wait <= 1'b1;
                    end else if (w_mm_done) begin
                        r_wait <= 1'b0;
                        r_sub  <= '0;
                        if (r_phase == PH_FN && r_mi == 2'd0) begin
                            r_omega <= w_mm_res;
                            r_mi    <= 2'd1;
                        end else begin
                            r_mi <= '0;
                            case (r_phase)
                                PH_BF: begin
                                    r_state <= S_TRD;
                                    if (r_j + 1'b1 != w_half) begin
                                        r_omega <= w_mm_res;
                                        r_j     <= r_j + 1'b1;
                                    end else begin
                                        r_omega <= DW'(1);
                                        r_j     <= '0;
                                        if (r_stage == rlwe_pkg::STG_W'(rlwe_pkg::NSTAGE - 1)) begin
                                            r_phase <= PH_MG;
                                        end else begin
                                            r_stage <= r_stage + 1'b1;
                                        end
                                    end
                                end
                                PH_MG: begin
                                    r_state <= S_TRD;
                                    if (r_j == JW'(rlwe_pkg::HALF - 1)) begin
                                        r_phase <= PH_FN;
                                        r_j     <= '0;
                                        r_omega <= DW'(1);
                                        r_wo    <= r_odd_twist;
                                    end else begin
                                        r_omega <= w_mm_res;
                                        r_j     <= r_j + 1'b1;
                                    end
                                end
                                default: begin
                                    r_wo <= w_mm_res;
                                    if (r_j == JW'(rlwe_pkg::HALF - 1)) begin
                                        r_j            <= '0;
                                        r_result_ready <= 1'b1;
                                        r_rd_idx       <= '0;
                                        r_state        <= S_IDLE;
                                    end else begin
                                        r_j     <= r_j + 1'b1;
                                        r_state <= S_TRD;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_data};
    assign o_m_axis_tlast  = r_out_last;

    a_ready_blocks_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_out_valid)
        else $error("input accepted while a result is pending");

    a_read_needs_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> r_result_ready)
        else $error("read issued with no results ready");

    a_mulmod_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |=> !w_mm_done)
        else $error("product finished one cycle after its start");

    a_store_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_wdata < w_q))
        else $error("unreduced value written to the coefficient store");

endmodule

`default_nettype wire
